### hw/rtl/mlfd_pkg.sv
// shared types and constants for the magic-length frame demux
// no dependencies
`default_nettype none

package mlfd_pkg;

    localparam int LEN_W = 12;
    localparam int BYTE_W = 8;
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = 12'd4088;

    typedef enum logic [1:0] {
        KIND_CONSOLE = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_DROP    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_PAY  = 2'd2
    } t_phase;

    // one classified request: held magic bytes to release, then optionally one more result
    typedef struct packed {
        logic [1:0]        rel;
        logic              cur;
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  flen;
        logic              fend;
    } t_cmd;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] value;
        logic [LEN_W-1:0]  flen;
        logic              fend;
        logic              run_last;
    } t_res;

    function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        begin
            case (idx)
                2'd0:    b = 8'h50;
                2'd1:    b = 8'h4F;
                2'd2:    b = 8'h4B;
                default: b = 8'h45;
            endcase
            return b;
        end
    endfunction

endpackage

`default_nettype wire

### hw/rtl/mlfd_queue.sv
// small first-in first-out queue of packed words
// no package dependencies
`default_nettype none

module mlfd_queue #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == DEPTH_C);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == LAST_P) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == LAST_P) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mlfd_front.sv
// front end: takes received bytes, tracks magic/length/payload, emits requests
// depends on mlfd_pkg
`default_nettype none

module mlfd_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [mlfd_pkg::LEN_W-1:0] i_cfg_data,
    input  wire logic                      i_push,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_cmd_full,
    output logic                           o_cmd_push,
    output mlfd_pkg::t_cmd                 o_cmd
);
    import mlfd_pkg::*;

    logic [LEN_W-1:0] r_max;
    t_phase           r_phase, n_phase;
    logic [1:0]       r_held, n_held;
    logic [1:0]       r_seen, n_seen;
    logic [LEN_W-1:0] r_len_lo, n_len_lo;
    logic             r_len_hi, n_len_hi;
    logic [LEN_W-1:0] r_left, n_left;
    logic             accept;
    logic             hi_all;

    assign accept = i_push & ~i_cmd_full;

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_seen     = r_seen;
        n_len_lo   = r_len_lo;
        n_len_hi   = r_len_hi;
        n_left     = r_left;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        hi_all     = r_len_hi | (i_rx_byte != 8'd0);
        case (r_phase)
            PH_LEN: begin
                n_seen = r_seen + 2'd1;
                case (r_seen)
                    2'd0: n_len_lo[7:0] = i_rx_byte;
                    2'd1: begin
                        n_len_lo[11:8] = i_rx_byte[3:0];
                        n_len_hi       = r_len_hi | (i_rx_byte[7:4] != 4'd0);
                    end
                    2'd2: n_len_hi = hi_all;
                    default: begin
                        n_len_lo   = '0;
                        n_len_hi   = 1'b0;
                        n_held     = 2'd0;
                        o_cmd_push = 1'b1;
                        o_cmd.cur  = 1'b1;
                        if (hi_all || (r_len_lo > r_max)) begin
                            o_cmd.kind = KIND_DROP;
                            n_phase    = PH_HUNT;
                        end else if (r_len_lo == '0) begin
                            o_cmd.kind = KIND_HEADER;
                            o_cmd.fend = 1'b1;
                            n_phase    = PH_HUNT;
                        end else begin
                            o_cmd.kind = KIND_HEADER;
                            o_cmd.flen = r_len_lo;
                            n_left     = r_len_lo;
                            n_phase    = PH_PAY;
                        end
                    end
                endcase
            end
            PH_PAY: begin
                n_left      = r_left - 1'b1;
                o_cmd_push  = 1'b1;
                o_cmd.cur   = 1'b1;
                o_cmd.kind  = KIND_PAYLOAD;
                o_cmd.value = i_rx_byte;
                o_cmd.fend  = (n_left == '0);
                if (n_left == '0) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (i_rx_byte == magic_byte(r_held)) begin
                    if (r_held == 2'd3) begin
                        n_phase  = PH_LEN;
                        n_held   = 2'd0;
                        n_seen   = 2'd0;
                        n_len_lo = '0;
                        n_len_hi = 1'b0;
                    end else begin
                        n_held = r_held + 2'd1;
                    end
                end else begin
                    o_cmd.rel  = r_held;
                    o_cmd.kind = KIND_CONSOLE;
                    if (i_rx_byte == magic_byte(2'd0)) begin
                        // restart the match on this byte, only the held ones go out
                        n_held     = 2'd1;
                        o_cmd_push = 1'b1;
                    end else begin
                        n_held      = 2'd0;
                        o_cmd_push  = 1'b1;
                        o_cmd.cur   = 1'b1;
                        o_cmd.value = i_rx_byte;
                    end
                end
            end
        endcase
        // a request leaves only with an accepted byte
        o_cmd_push = o_cmd_push & accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_PAYLOAD_RST;
            r_phase  <= PH_HUNT;
            r_held   <= 2'd0;
            r_seen   <= 2'd0;
            r_len_lo <= '0;
            r_len_hi <= 1'b0;
            r_left   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_held   <= n_held;
                r_seen   <= n_seen;
                r_len_lo <= n_len_lo;
                r_len_hi <= n_len_hi;
                r_left   <= n_left;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mlfd_back.sv
// back end: expands one request into its results, one per cycle while a request waits and the result queue has room
// depends on mlfd_pkg
`default_nettype none

module mlfd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cmd_empty,
    input  wire mlfd_pkg::t_cmd i_cmd,
    output logic                o_cmd_pop,
    input  wire logic           i_res_full,
    output logic                o_res_push,
    output mlfd_pkg::t_res      o_res
);
    import mlfd_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       go;

    assign go = ~i_cmd_empty & ~i_res_full;

    always_comb begin
        n_idx      = r_idx;
        o_cmd_pop  = 1'b0;
        o_res_push = go;
        o_res      = '0;
        if (r_idx < i_cmd.rel) begin
            o_res.kind     = KIND_CONSOLE;
            o_res.value    = magic_byte(r_idx);
            o_res.run_last = (r_idx == i_cmd.rel - 2'd1) & ~i_cmd.cur;
        end else begin
            o_res.kind     = i_cmd.kind;
            o_res.value    = i_cmd.value;
            o_res.flen     = i_cmd.flen;
            o_res.fend     = i_cmd.fend;
            o_res.run_last = 1'b1;
        end
        if (go) begin
            if (o_res.run_last) begin
                o_cmd_pop = 1'b1;
                n_idx     = 2'd0;
            end else begin
                n_idx = r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/magic_length_frame_demux.sv
// top level of the magic-length frame demux: front end, request queue, back end, result queue
// depends on mlfd_pkg, mlfd_queue, mlfd_front, mlfd_back
`default_nettype none

// Splits a received byte stream into framed messages and console bytes. A frame is the
// four magic bytes 50 4F 4B 45 hex, a 32-bit little-endian payload length, then the payload.
// Both sides look like a queue: push a byte while full is low, pop results while empty
// is low. Each result carries kind (console, header, payload, dropped header), the byte, the
// frame length on headers, a frame end flag and run_last, which marks the final result caused
// by one input byte. One byte is accepted per cycle while full is low; results pass through
// the request queue and the result queue. A byte that breaks a partial magic match causes up
// to four results; the back end emits one per cycle while the result queue has room, and the
// request queue of CMD_DEPTH entries absorbs that burst. The max_payload register resets to
// 4088 and must be written only while idle.
module magic_length_frame_demux #(
    parameter int CMD_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // config: max payload length
    input  wire logic                       i_cfg_we,
    input  wire logic [mlfd_pkg::LEN_W-1:0] i_cfg_data,
    // byte input
    input  wire logic                       push,
    input  wire logic [7:0]                 i_rx_byte,
    output logic                            full,
    // result output
    output logic                            empty,
    input  wire logic                       pop,
    output logic [1:0]                      o_kind,
    output logic [7:0]                      o_value,
    output logic [11:0]                     o_frame_length,
    output logic                            o_frame_end,
    output logic                            o_run_last
);
    import mlfd_pkg::*;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    // front to request queue
    t_cmd             cmd_in, cmd_head;
    logic [CMD_W-1:0] cmd_in_vec, cmd_head_vec;
    logic             cmd_push, cmd_full, cmd_empty, cmd_pop;

    // back to result queue
    t_res             res_in, res_head;
    logic [RES_W-1:0] res_in_vec, res_head_vec;
    logic             res_push, res_full;

    assign full = cmd_full;

    mlfd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_rx_byte  (i_rx_byte),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    assign cmd_in_vec = cmd_in;

    // requests waiting for expansion
    mlfd_queue #(
        .DEPTH (CMD_DEPTH),
        .WIDTH (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in_vec),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head_vec),
        .o_empty (cmd_empty)
    );

    assign cmd_head = t_cmd'(cmd_head_vec);

    mlfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    assign res_in_vec = res_in;

    // finished results, decouples the consumer from the back end
    mlfd_queue #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in_vec),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_head_vec),
        .o_empty (empty)
    );

    assign res_head       = t_res'(res_head_vec);
    assign o_kind         = res_head.kind;
    assign o_value        = res_head.value;
    assign o_frame_length = res_head.flen;
    assign o_frame_end    = res_head.fend;
    assign o_run_last     = res_head.run_last;

endmodule

`default_nettype wire
